// File: sv/pcrc_pkg.sv
// ----------------------------------------------------------------------------
// pcrc_pkg
// Shared types and constants for the programmable bit-serial CRC.
// ----------------------------------------------------------------------------
package pcrc_pkg;

  localparam int MAX_DEGREE = 32;
  localparam int REM_W      = MAX_DEGREE;
  localparam int CNT_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int DEG_W      = 6;
  localparam int COEF_W     = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int EXT_W      = (REM_W > COEF_W) ? REM_W : COEF_W;

  localparam logic [DEG_W-1:0]  DEGREE_RESET = DEG_W'(16);
  localparam logic [COEF_W-1:0] COEFFS_RESET = COEF_W'(32'h0000_1021);

  localparam logic [CFG_IDX_W-1:0] REG_GEN_DEGREE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GEN_LOW_COEFFS = CFG_IDX_W'(1);

  typedef struct packed {
    logic message_bit;
    logic last_bit;
  } pcrc_in_t;

  typedef struct packed {
    logic check_bit;
    logic last_check;
    logic remainder_zero;
  } pcrc_out_t;

  typedef struct packed {
    logic [DEG_W-1:0]  gen_degree;
    logic [COEF_W-1:0] gen_low_coeffs;
  } pcrc_cfg_t;

  // snapshot handed from the divider to the output shifter
  typedef struct packed {
    logic             load;
    logic [REM_W-1:0] rem;
    logic [CNT_W-1:0] deg_m1;
    logic             zero;
  } pcrc_load_t;

endpackage

// File: sv/programmable_crc_bit_serial.sv
// ----------------------------------------------------------------------------
// programmable_crc_bit_serial
// Bit-serial CRC with programmable generator degree and coefficients.
// ----------------------------------------------------------------------------
// Input channel: one message bit per transaction, MSB first; last_bit marks
// the final bit. Each accepted bit runs one division step into the remainder
// register in the same cycle, so a bit can be taken every cycle unless stalled.
// Output channel: on the final bit the remainder (degree bits) is copied to an
// output shifter and leaves one bit per transaction, MSB first, starting the
// cycle after the final bit is accepted. last_check marks the last remainder
// bit; remainder_zero is the same on every bit of a run.
// Throughput: 1 bit per cycle while in_stall is low. Bits of the next message
// are accepted while the previous remainder drains; only a new final bit waits
// (in_stall) until the shifter is free or is sending its last bit.
// Receiver stall: the shifter holds its current bit, nothing is lost.
// Reset: remainder cleared, shifter empty, degree 16, coefficients 0x1021.
// Configuration: write only between messages with no output pending.
// ----------------------------------------------------------------------------
module programmable_crc_bit_serial (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pcrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcrc_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pcrc_pkg::pcrc_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pcrc_pkg::pcrc_out_t              out_data
);
  import pcrc_pkg::*;

  pcrc_cfg_t  cfg_r;
  pcrc_cfg_t  cfg_nxt;
  pcrc_load_t load;
  logic       drain_busy;
  logic       drain_done;
  logic       in_fire;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_GEN_DEGREE:     cfg_nxt.gen_degree     = cfg_wdata[DEG_W-1:0];
        REG_GEN_LOW_COEFFS: cfg_nxt.gen_low_coeffs = cfg_wdata[COEF_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gen_degree     <= DEGREE_RESET;
      cfg_r.gen_low_coeffs <= COEFFS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // only a final bit needs the shifter
  assign in_stall = drain_busy && in_data.last_bit && !drain_done;
  assign in_fire  = in_valid && !in_stall;

  pcrc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_fire (in_fire),
    .in_data (in_data),
    .load    (load)
  );

  pcrc_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .busy      (drain_busy),
    .done_now  (drain_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: sv/pcrc_core.sv
// ----------------------------------------------------------------------------
// pcrc_core
// Remainder register and one shift/XOR division step per accepted bit.
// ----------------------------------------------------------------------------
module pcrc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  pcrc_pkg::pcrc_cfg_t cfg,
  input  logic                in_fire,
  input  pcrc_pkg::pcrc_in_t  in_data,
  output pcrc_pkg::pcrc_load_t load
);
  import pcrc_pkg::*;

  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] rem_nxt;
  logic [DEG_W:0]   deg_eff;
  logic [CNT_W-1:0] deg_m1;
  logic [REM_W-1:0] mask;
  logic [EXT_W-1:0] coef_ext;
  logic [REM_W-1:0] poly;
  logic [REM_W-1:0] rem_masked;
  logic [REM_W-1:0] rem_step;
  logic             fb;

  // clamp the programmed degree to 1..MAX_DEGREE
  always_comb begin
    if (cfg.gen_degree == '0) begin
      deg_eff = (DEG_W+1)'(1);
    end else if ({1'b0, cfg.gen_degree} > (DEG_W+1)'(MAX_DEGREE)) begin
      deg_eff = (DEG_W+1)'(MAX_DEGREE);
    end else begin
      deg_eff = {1'b0, cfg.gen_degree};
    end
  end

  assign deg_m1 = CNT_W'(deg_eff - (DEG_W+1)'(1));

  always_comb begin
    for (int i = 0; i < REM_W; i++) begin
      mask[i] = (i < int'(deg_eff));
    end
  end

  assign coef_ext   = EXT_W'(cfg.gen_low_coeffs);
  assign poly       = coef_ext[REM_W-1:0] & mask;
  assign rem_masked = rem_r & mask;
  assign fb         = rem_masked[deg_m1] ^ in_data.message_bit;
  assign rem_step   = ((rem_masked << 1) & mask) ^ (fb ? poly : '0);

  always_comb begin
    rem_nxt = rem_r;
    if (in_fire) begin
      rem_nxt = in_data.last_bit ? '0 : rem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  assign load.load   = in_fire && in_data.last_bit;
  assign load.rem    = rem_step;
  assign load.deg_m1 = deg_m1;
  assign load.zero   = (rem_step == '0);

endmodule

// File: sv/pcrc_drain.sv
// ----------------------------------------------------------------------------
// pcrc_drain
// Holds a finished remainder and sends it out one bit per transaction, MSB first.
// ----------------------------------------------------------------------------
module pcrc_drain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pcrc_pkg::pcrc_load_t load,
  output logic                 busy,
  output logic                 done_now,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pcrc_pkg::pcrc_out_t  out_data
);
  import pcrc_pkg::*;

  logic             busy_r;
  logic             busy_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [REM_W-1:0] snap_r;
  logic [REM_W-1:0] snap_nxt;
  logic             zero_r;
  logic             zero_nxt;
  logic             out_fire;

  assign out_fire = busy_r && !out_stall;
  assign done_now = out_fire && (cnt_r == '0);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    snap_nxt = snap_r;
    zero_nxt = zero_r;
    if (out_fire) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
    // top level only loads when idle or on the final bit going out
    if (load.load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = load.deg_m1;
      snap_nxt = load.rem;
      zero_nxt = load.zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
    zero_r <= zero_nxt;
  end

  assign busy                    = busy_r;
  assign out_valid               = busy_r;
  assign out_data.check_bit      = snap_r[cnt_r];
  assign out_data.last_check     = (cnt_r == '0);
  assign out_data.remainder_zero = zero_r;

endmodule

// File: sv/pcrc_checker.sv
// ----------------------------------------------------------------------------
// pcrc_checker
// Port-level checks for the programmable bit-serial CRC.
// ----------------------------------------------------------------------------
module pcrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input pcrc_pkg::pcrc_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input pcrc_pkg::pcrc_out_t out_data
);
  import pcrc_pkg::*;

  // nothing pending out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  // a final bit always starts a remainder burst next cycle
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_bit |=> out_valid)
    else $error("no remainder after final bit");

  // a burst is not cut short before last_check
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_check |=> out_valid)
    else $error("remainder burst broken");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_check
      |=> out_data.remainder_zero == $past(out_data.remainder_zero))
    else $error("remainder_zero changed within a burst");

endmodule

bind programmable_crc_bit_serial pcrc_checker u_pcrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
